// File: design/tve_pkg.sv
// Package for the tagged value byte encoder: commands, status codes, header bytes,
// register map, and the queue entry that links the front and back parts.
// No dependencies.
`default_nettype none

package tve_pkg;

    localparam int BYTE_COUNT_W   = 21;
    localparam int LIMIT_W        = 21;
    localparam int DEPTH_W        = 4;
    localparam int VALUE_W        = 64;
    localparam int CMD_W          = 4;
    localparam int STATUS_W       = 2;
    localparam int MAX_BYTES      = 9;
    localparam int NBYTES_W       = 4;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam int DEF_BUFFER_BYTES = 1048576;
    localparam int DEF_QUEUE_DEPTH  = 4;

    localparam logic [LIMIT_W-1:0] BUFFER_LIMIT_RST = 21'd1048576;
    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST    = 4'd12;

    // register index = paddr[2]
    localparam logic REG_BUFFER_LIMIT = 1'b0;
    localparam logic REG_MAX_DEPTH    = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN     = 4'd0,
        CMD_NIL       = 4'd1,
        CMD_BOOLEAN   = 4'd2,
        CMD_INTEGER   = 4'd3,
        CMD_DOUBLE    = 4'd4,
        CMD_POINTER   = 4'd5,
        CMD_STR_HDR   = 4'd6,
        CMD_STR_BYTE  = 4'd7,
        CMD_TABLE_HDR = 4'd8,
        CMD_TABLE_END = 4'd9
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BUF_FULL  = 2'd1,
        ST_TOO_DEEP  = 2'd2
    } status_t;

    localparam logic [7:0] HDR_NIL        = 8'h00;
    localparam logic [7:0] HDR_BOOL       = 8'h01;
    localparam logic [7:0] HDR_INT_ZERO   = 8'h02;
    localparam logic [7:0] HDR_INT_BYTE   = 8'h0A;
    localparam logic [7:0] HDR_INT_WORD   = 8'h12;
    localparam logic [7:0] HDR_INT_DWORD  = 8'h22;
    localparam logic [7:0] HDR_INT_QWORD  = 8'h32;
    localparam logic [7:0] HDR_DOUBLE     = 8'h42;
    localparam logic [7:0] HDR_POINTER    = 8'h03;
    localparam logic [7:0] HDR_SHORT_STR  = 8'h04;
    localparam logic [7:0] HDR_STR_LEN16  = 8'h15;
    localparam logic [7:0] HDR_STR_LEN32  = 8'h25;
    localparam logic [7:0] HDR_TABLE      = 8'h06;
    localparam logic [7:0] HDR_TABLE_BIG  = 8'hFE;
    localparam logic [7:0] HDR_TABLE_END  = 8'h00;

    localparam int SHORT_STR_MAX  = 32;
    localparam int SHORT_TBL_MAX  = 31;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;   // byte 0 goes out first
        logic [NBYTES_W-1:0]       nbytes;  // 1..9
        status_t                   status;
    } tve_entry_t;

endpackage

`default_nettype wire

// File: design/tagged_value_byte_encoder.sv
// Tagged value byte encoder: front, queue and back, plus the APB register file.
// Depends on tve_pkg, tve_front, tve_fifo and tve_back.
// An item's beat is written into the queue; its bytes then pass the output register to
// m_tdata. Throughput: one output beat per cycle while m_tready is high; an n-byte item
// (1 to 9 bytes) is n beats, and the front takes a beat every cycle while the queue has room.
// Reset: rst_n clears byte count, depth, error flag, queue and output; registers
// return to buffer_limit 1048576 and max_depth 12.
`default_nettype none

module tagged_value_byte_encoder #(
    parameter int BUFFER_BYTES = tve_pkg::DEF_BUFFER_BYTES,
    parameter int QUEUE_DEPTH  = tve_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [71:0]                     s_tdata,   // command[3:0], value[67:4], zero pad
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [7:0]                           m_tdata,   // data_byte[7:0]
    output logic                                 m_tlast,
    output logic [tve_pkg::STATUS_W-1:0]         m_tuser,   // status[1:0]
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tve_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [tve_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tve_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    import tve_pkg::*;

    logic [LIMIT_W-1:0] buffer_limit_reg;
    logic [DEPTH_W-1:0] max_depth_reg;
    logic               cfg_write;
    logic               push;
    logic               pop;
    logic               queue_full;
    logic               queue_empty;
    tve_entry_t         push_entry;
    tve_entry_t         head_entry;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_limit_reg <= BUFFER_LIMIT_RST;
            max_depth_reg    <= MAX_DEPTH_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_BUFFER_LIMIT: buffer_limit_reg <= pwdata[LIMIT_W-1:0];
                REG_MAX_DEPTH:    max_depth_reg    <= pwdata[DEPTH_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_BUFFER_LIMIT: prdata = APB_DATA_W'(buffer_limit_reg);
            REG_MAX_DEPTH:    prdata = APB_DATA_W'(max_depth_reg);
            default:          prdata = '0;
        endcase
    end

    tve_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .command      (s_tdata[3:0]),
        .value        (s_tdata[67:4]),
        .buffer_limit (buffer_limit_reg),
        .max_depth    (max_depth_reg),
        .push         (push),
        .entry        (push_entry),
        .queue_full   (queue_full)
    );

    tve_fifo #(
        .Width ($bits(tve_entry_t)),
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_entry),
        .full  (queue_full),
        .pop   (pop),
        .rdata (head_entry),
        .empty (queue_empty)
    );

    tve_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_entry),
        .head_empty (queue_empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_last   (m_tlast),
        .out_status (m_tuser)
    );

endmodule

`default_nettype wire

// File: design/tve_fifo.sv
// Small show-ahead queue between the front and back parts.
// Generic width and depth; no package dependency.
`default_nettype none

module tve_fifo #(
    parameter int Width = 8,
    parameter int Depth = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [Width-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [Width-1:0]      rdata,
    output logic                  empty
);

    localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CountW = $clog2(Depth + 1);
    localparam logic [AddrW-1:0]  LastAddr = AddrW'(Depth - 1);
    localparam logic [CountW-1:0] FullCount = CountW'(Depth);

    logic [Width-1:0]  mem_reg [Depth];
    logic [AddrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AddrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == FullCount);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastAddr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastAddr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: design/tve_front.sv
// Front part: accepts command beats, builds the byte image of each value,
// checks depth and buffer limits, and keeps byte count, depth and error state.
// Depends on tve_pkg.
`default_nettype none

module tve_front #(
    parameter int BUFFER_BYTES = tve_pkg::DEF_BUFFER_BYTES
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [tve_pkg::CMD_W-1:0]        command,
    input  wire logic [tve_pkg::VALUE_W-1:0]      value,
    input  wire logic [tve_pkg::LIMIT_W-1:0]      buffer_limit,
    input  wire logic [tve_pkg::DEPTH_W-1:0]      max_depth,
    output logic                                  push,
    output tve_pkg::tve_entry_t                   entry,
    input  wire logic                             queue_full
);

    import tve_pkg::*;

    localparam int BufW = $clog2(BUFFER_BYTES + 1);
    localparam int LimW = ((BufW > LIMIT_W) ? BufW : LIMIT_W) + 1;
    localparam logic [LimW-1:0] BufBytes = LimW'(BUFFER_BYTES);

    typedef struct packed {
        logic [7:0]          hdr;
        logic [NBYTES_W-1:0] len;
    } int_form_t;

    logic [BYTE_COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [DEPTH_W-1:0]      nest_depth_reg, nest_depth_next;
    logic                    error_reg, error_next;

    logic                    accept;
    logic [7:0]              hdr0;
    logic [7:0]              hdr1;
    logic                    has_hdr1;
    logic [VALUE_W-1:0]      payload;
    logic [NBYTES_W-1:0]     pay_len;
    logic [NBYTES_W-1:0]     nbytes;
    logic                    emits;
    logic                    opens;
    logic                    closes;
    logic                    too_deep;
    logic                    buf_full;
    logic [31:0]             str_len;
    logic [30:0]             tbl_size;
    logic [DEPTH_W:0]        depth_inc;
    logic [LimW-1:0]         limit;
    logic [LimW-1:0]         count_sum;
    int_form_t               int_form;
    int_form_t               tbl_form;

    // shortest integer form; negative values that fit 32 bits go out as dword
    function automatic int_form_t enc_int(input logic [VALUE_W-1:0] v);
        int_form_t f;
        logic      fits32;
        fits32 = (v[63:31] == '0) || (v[63:31] == '1);
        if (v == '0)
        begin
            f.hdr = HDR_INT_ZERO;
            f.len = NBYTES_W'(0);
        end
        else if (!fits32)
        begin
            f.hdr = HDR_INT_QWORD;
            f.len = NBYTES_W'(8);
        end
        else if (v[63])
        begin
            f.hdr = HDR_INT_DWORD;
            f.len = NBYTES_W'(4);
        end
        else if (v[63:8] == '0)
        begin
            f.hdr = HDR_INT_BYTE;
            f.len = NBYTES_W'(1);
        end
        else if (v[63:16] == '0)
        begin
            f.hdr = HDR_INT_WORD;
            f.len = NBYTES_W'(2);
        end
        else
        begin
            f.hdr = HDR_INT_DWORD;
            f.len = NBYTES_W'(4);
        end
        return f;
    endfunction

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    assign str_len  = (value[63:32] != '0) ? 32'hFFFF_FFFF : value[31:0];
    assign tbl_size = value[63] ? '0 : ((value[62:31] != '0) ? '1 : value[30:0]);
    assign int_form = enc_int(value);
    assign tbl_form = enc_int({33'd0, tbl_size});

    always_comb
    begin
        hdr0     = HDR_NIL;
        hdr1     = HDR_NIL;
        has_hdr1 = 1'b0;
        payload  = value;
        pay_len  = '0;
        emits    = 1'b1;
        opens    = 1'b0;
        closes   = 1'b0;
        case (command)
            CMD_NIL:
            begin
                hdr0 = HDR_NIL;
            end
            CMD_BOOLEAN:
            begin
                hdr0 = HDR_BOOL | {4'd0, (value != '0), 3'd0};
            end
            CMD_INTEGER:
            begin
                hdr0    = int_form.hdr;
                pay_len = int_form.len;
            end
            CMD_DOUBLE:
            begin
                hdr0    = HDR_DOUBLE;
                pay_len = NBYTES_W'(8);
            end
            CMD_POINTER:
            begin
                hdr0    = HDR_POINTER;
                pay_len = NBYTES_W'(8);
            end
            CMD_STR_HDR:
            begin
                payload = {32'd0, str_len};
                if (str_len < 32'(SHORT_STR_MAX))
                begin
                    hdr0 = HDR_SHORT_STR | {str_len[4:0], 3'd0};
                end
                else if (str_len[31:16] == '0)
                begin
                    hdr0    = HDR_STR_LEN16;
                    pay_len = NBYTES_W'(2);
                end
                else
                begin
                    hdr0    = HDR_STR_LEN32;
                    pay_len = NBYTES_W'(4);
                end
            end
            CMD_STR_BYTE:
            begin
                hdr0 = value[7:0];
            end
            CMD_TABLE_HDR:
            begin
                opens   = 1'b1;
                payload = {33'd0, tbl_size};
                if (tbl_size >= 31'(SHORT_TBL_MAX))
                begin
                    hdr0     = HDR_TABLE_BIG;
                    hdr1     = tbl_form.hdr;
                    has_hdr1 = 1'b1;
                    pay_len  = tbl_form.len;
                end
                else
                begin
                    hdr0 = HDR_TABLE | {tbl_size[4:0], 3'd0};
                end
            end
            CMD_TABLE_END:
            begin
                hdr0   = HDR_TABLE_END;
                closes = 1'b1;
            end
            default:
            begin
                emits = 1'b0;   // begin and unknown commands
            end
        endcase
    end

    assign nbytes    = NBYTES_W'(1) + NBYTES_W'(has_hdr1) + pay_len;
    assign depth_inc = {1'b0, nest_depth_reg} + 1'b1;
    assign too_deep  = opens && (depth_inc > {1'b0, max_depth});
    assign limit     = (LimW'(buffer_limit) < BufBytes) ? LimW'(buffer_limit) : BufBytes;
    assign count_sum = LimW'(byte_count_reg) + LimW'(nbytes);
    assign buf_full  = count_sum >= limit;

    always_comb
    begin
        byte_count_next = byte_count_reg;
        nest_depth_next = nest_depth_reg;
        error_next      = error_reg;
        push            = 1'b0;
        entry.bytes     = has_hdr1 ? {payload[55:0], hdr1, hdr0} : {payload, hdr0};
        entry.nbytes    = nbytes;
        entry.status    = ST_OK;
        if (accept)
        begin
            if (command == CMD_BEGIN)
            begin
                byte_count_next = '0;
                nest_depth_next = '0;
                error_next      = 1'b0;
            end
            else if (emits && !error_reg)
            begin
                push = 1'b1;
                if (too_deep || buf_full)
                begin
                    entry.bytes  = '0;
                    entry.nbytes = NBYTES_W'(1);
                    entry.status = too_deep ? ST_TOO_DEEP : ST_BUF_FULL;
                    error_next   = 1'b1;
                end
                else
                begin
                    byte_count_next = count_sum[BYTE_COUNT_W-1:0];
                    if (opens)
                    begin
                        nest_depth_next = depth_inc[DEPTH_W-1:0];
                    end
                    if (closes && (nest_depth_reg != '0))
                    begin
                        nest_depth_next = nest_depth_reg - 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            nest_depth_reg <= '0;
            error_reg      <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            nest_depth_reg <= nest_depth_next;
            error_reg      <= error_next;
        end
    end

endmodule

`default_nettype wire

// File: design/tve_back.sv
// Back part: walks queued bytes into the output register, one per cycle unless stalled.
// Depends on tve_pkg.
`default_nettype none

module tve_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tve_pkg::tve_entry_t          head,
    input  wire logic                         head_empty,
    output logic                              pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [7:0]                        out_byte,
    output logic                              out_last,
    output logic [tve_pkg::STATUS_W-1:0]      out_status
);

    import tve_pkg::*;

    logic [NBYTES_W-1:0] idx_reg, idx_next;
    logic                valid_reg, valid_next;
    logic [7:0]          byte_reg;
    logic                last_reg;
    status_t             status_reg;
    logic                load;
    logic                is_last;

    assign load    = !head_empty && (!valid_reg || out_ready);
    assign is_last = (idx_reg == (head.nbytes - 1'b1));
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_last ? '0 : idx_reg + 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= head.bytes[idx_reg];
            last_reg   <= is_last;
            status_reg <= head.status;
        end
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign out_last   = last_reg;
    assign out_status = status_reg;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking bench for tagged_value_byte_encoder: drives value beats on the slave
// stream, predicts the serialized bytes and compares every master beat in order.
// Depends on tve_pkg and the encoder RTL.

module tb_top;
    import tve_pkg::*;

    localparam int BUF_BYTES    = DEF_BUFFER_BYTES;
    localparam int ITEM_TARGET  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [APB_ADDR_W-1:0] ADDR_BUFFER_LIMIT = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_DEPTH    = 3'd4;
    localparam logic [CMD_W-1:0]      CMD_UNUSED_LO     = 4'd10;

    typedef struct {
        logic [7:0] data;
        logic       last;
        status_t    st;
    } beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [71:0]           s_tdata = '0;   // command[3:0], value[67:4], zero pad
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;        // data_byte[7:0]
    logic                  m_tlast;
    logic [STATUS_W-1:0]   m_tuser;        // status[1:0]
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // encoder state mirrored by the bench
    logic [LIMIT_W-1:0]      limit_reg = BUFFER_LIMIT_RST;
    logic [DEPTH_W-1:0]      max_depth_reg = MAX_DEPTH_RST;
    logic [BYTE_COUNT_W-1:0] byte_total = '0;
    logic [DEPTH_W-1:0]      nest_depth = '0;
    logic                    err_pending = 1'b0;

    logic [7:0] enc_buf[$];
    beat_t      expected_beats[$];
    beat_t      exp_beat;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int error_count = 0;
    int handled_items = 0;
    int refused_items = 0;
    int beats_checked = 0;

    tagged_value_byte_encoder #(.BUFFER_BYTES(BUF_BYTES)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // ---------------- prediction ----------------

    function automatic void put_le(logic [63:0] v, int count);
        int i;
        for (i = 0; i < count; i++)
            enc_buf.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_integer(logic [63:0] v);
        logic [63:0] biased;
        biased = v + 64'h8000_0000;
        if (v == 64'd0)
            enc_buf.push_back(HDR_INT_ZERO);
        else if (biased >= 64'h1_0000_0000) begin
            enc_buf.push_back(HDR_INT_QWORD);
            put_le(v, 8);
        end
        else if (v[63]) begin
            enc_buf.push_back(HDR_INT_DWORD);
            put_le(v, 4);
        end
        else if (v < 64'h100) begin
            enc_buf.push_back(HDR_INT_BYTE);
            put_le(v, 1);
        end
        else if (v < 64'h1_0000) begin
            enc_buf.push_back(HDR_INT_WORD);
            put_le(v, 2);
        end
        else begin
            enc_buf.push_back(HDR_INT_DWORD);
            put_le(v, 4);
        end
    endfunction

    function automatic void refuse_item(status_t code);
        beat_t b;
        err_pending = 1'b1;
        refused_items++;
        b.data = 8'h00;
        b.last = 1'b1;
        b.st   = code;
        expected_beats.push_back(b);
    endfunction

    function automatic void encode_item(logic [CMD_W-1:0] cmd, logic [63:0] val);
        logic [63:0] len;
        logic [63:0] sz;
        bit          opens;
        bit          closes;
        int          lim;
        int          i;
        beat_t       b;
        opens  = 0;
        closes = 0;
        enc_buf.delete();
        if (cmd == CMD_BEGIN) begin
            byte_total  = '0;
            nest_depth  = '0;
            err_pending = 1'b0;
            handled_items++;
            return;
        end
        if (cmd > CMD_TABLE_END || err_pending)
            return;
        handled_items++;
        case (cmd)
            CMD_NIL:      enc_buf.push_back(HDR_NIL);
            CMD_BOOLEAN:  enc_buf.push_back(HDR_BOOL | ((val != 64'd0) ? 8'h08 : 8'h00));
            CMD_INTEGER:  put_integer(val);
            CMD_DOUBLE:
            begin
                enc_buf.push_back(HDR_DOUBLE);
                put_le(val, 8);
            end
            CMD_POINTER:
            begin
                enc_buf.push_back(HDR_POINTER);
                put_le(val, 8);
            end
            CMD_STR_HDR:
            begin
                len = (val > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : val;
                if (len < SHORT_STR_MAX)
                    enc_buf.push_back(HDR_SHORT_STR | {len[4:0], 3'b000});
                else if (len < 64'h1_0000) begin
                    enc_buf.push_back(HDR_STR_LEN16);
                    put_le(len, 2);
                end
                else begin
                    enc_buf.push_back(HDR_STR_LEN32);
                    put_le(len, 4);
                end
            end
            CMD_STR_BYTE: enc_buf.push_back(val[7:0]);
            CMD_TABLE_HDR:
            begin
                if (val[63])
                    sz = 64'd0;
                else if (val > 64'h7FFF_FFFF)
                    sz = 64'h7FFF_FFFF;
                else
                    sz = val;
                // depth is checked ahead of the buffer
                if (int'(nest_depth) + 1 > int'(max_depth_reg)) begin
                    refuse_item(ST_TOO_DEEP);
                    return;
                end
                if (sz >= SHORT_TBL_MAX) begin
                    enc_buf.push_back(HDR_TABLE_BIG);
                    put_integer(sz);
                end
                else
                    enc_buf.push_back(HDR_TABLE | {sz[4:0], 3'b000});
                opens = 1;
            end
            default:
            begin
                enc_buf.push_back(HDR_TABLE_END);
                closes = 1;
            end
        endcase
        lim = (int'(limit_reg) < BUF_BYTES) ? int'(limit_reg) : BUF_BYTES;
        if (int'(byte_total) + enc_buf.size() >= lim) begin
            refuse_item(ST_BUF_FULL);
            return;
        end
        byte_total = byte_total + BYTE_COUNT_W'(enc_buf.size());
        if (opens)
            nest_depth = nest_depth + 1'b1;
        if (closes && nest_depth != 0)
            nest_depth = nest_depth - 1'b1;
        for (i = 0; i < enc_buf.size(); i++) begin
            b.data = enc_buf[i];
            b.last = (i == enc_buf.size() - 1);
            b.st   = ST_OK;
            expected_beats.push_back(b);
        end
    endfunction

    // ---------------- drivers ----------------

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [63:0] val);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, val, cmd};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        encode_item(cmd, val);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_BUFFER_LIMIT)
            limit_reg = data[LIMIT_W-1:0];
        else
            max_depth_reg = data[DEPTH_W-1:0];
        @(posedge clk);
    endtask

    // ---------------- receiver and checker ----------------

    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                error_count++;
                $display("%0t: unexpected beat data %h last %b status %0d",
                         $time, m_tdata, m_tlast, m_tuser);
            end
            else begin
                exp_beat = expected_beats.pop_front();
                beats_checked++;
                if (m_tdata !== exp_beat.data) begin
                    error_count++;
                    $display("%0t: data_byte expected %h got %h", $time, exp_beat.data, m_tdata);
                end
                if (m_tlast !== exp_beat.last) begin
                    error_count++;
                    $display("%0t: last expected %b got %b", $time, exp_beat.last, m_tlast);
                end
                if (m_tuser !== exp_beat.st) begin
                    error_count++;
                    $display("%0t: status expected %0d got %0d", $time, exp_beat.st, m_tuser);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats outstanding", $time, expected_beats.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    function automatic logic [63:0] rand_value();
        case ($urandom_range(7))
            0: return 64'd0;
            1: return 64'($urandom_range(255));
            2: return 64'($urandom_range(65535));
            3: return {32'd0, $urandom};
            4: return {32'hFFFF_FFFF, 1'b1, 31'($urandom)};
            5:
            begin
                case ($urandom_range(5))
                    0: return 64'h8000_0000_0000_0000;
                    1: return 64'h7FFF_FFFF_FFFF_FFFF;
                    2: return 64'hFFFF_FFFF_FFFF_FFFF;
                    3: return 64'h0000_0000_8000_0000;
                    4: return 64'hFFFF_FFFF_7FFF_FFFF;
                    default: return 64'h0000_0001_0000_0000;
                endcase
            end
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_random_item();
        int r;
        int n;
        r = $urandom_range(99);
        if (err_pending && $urandom_range(3) != 0)
            send_item(CMD_BEGIN, rand_value());
        else if (r < 6)
            send_item(CMD_NIL, rand_value());
        else if (r < 14)
            send_item(CMD_BOOLEAN, ($urandom_range(1) != 0) ? rand_value() : 64'd0);
        else if (r < 34)
            send_item(CMD_INTEGER, rand_value());
        else if (r < 42)
            send_item(CMD_DOUBLE, {$urandom, $urandom});
        else if (r < 48)
            send_item(CMD_POINTER, {$urandom, $urandom});
        else if (r < 62) begin
            // string header followed by string byte beats, all of them for a short header
            if ($urandom_range(3) != 0) begin
                n = $urandom_range(6);
                send_item(CMD_STR_HDR, 64'(n));
            end
            else begin
                send_item(CMD_STR_HDR, rand_value());
                n = $urandom_range(3);
            end
            repeat (n) send_item(CMD_STR_BYTE, {$urandom, $urandom});
        end
        else if (r < 74)
            send_item(CMD_TABLE_HDR, ($urandom_range(2) != 0) ? 64'($urandom_range(40))
                                                              : rand_value());
        else if (r < 86) begin
            if (nest_depth != 0 || $urandom_range(4) == 0)
                send_item(CMD_TABLE_END, rand_value());
            else
                send_item(CMD_NIL, rand_value());
        end
        else if (r < 91)
            send_item(CMD_UNUSED_LO + 4'($urandom_range(5)), rand_value());
        else if (r < 94)
            send_item(CMD_BEGIN, rand_value());
        else
            send_item(CMD_STR_BYTE, {$urandom, $urandom});
    endtask

    task automatic test_scalar_forms();
        send_item(CMD_BEGIN, 64'd0);
        send_item(CMD_NIL, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_BOOLEAN, 64'd0);
        send_item(CMD_BOOLEAN, 64'h8000_0000_0000_0000);   // any nonzero is true
        send_item(CMD_INTEGER, 64'd0);
        send_item(CMD_INTEGER, 64'd255);
        send_item(CMD_INTEGER, 64'd256);
        send_item(CMD_INTEGER, 64'd65536);
        send_item(CMD_INTEGER, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_INTEGER, 64'hFFFF_FFFF_8000_0000);
        send_item(CMD_INTEGER, 64'h0000_0000_8000_0000);   // just over int32 max
        send_item(CMD_INTEGER, 64'h8000_0000_0000_0000);
        send_item(CMD_INTEGER, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(CMD_DOUBLE, {$urandom, $urandom});
        send_item(CMD_POINTER, 64'hFFFF_FFFF_FFFF_FFFF);
        wait_idle();
    endtask

    task automatic test_strings_tables();
        send_item(CMD_STR_HDR, 64'd31);
        send_item(CMD_STR_HDR, 64'd32);
        send_item(CMD_STR_HDR, 64'h1_0000);
        send_item(CMD_STR_HDR, 64'hFFFF_FFFF_FFFF_FFFF);   // saturates
        send_item(CMD_STR_BYTE, 64'hFFFF_FFFF_FFFF_FF5A);
        send_item(CMD_TABLE_HDR, 64'd30);
        send_item(CMD_TABLE_HDR, 64'd31);
        send_item(CMD_TABLE_HDR, 64'hFFFF_FFFF_FFFF_FFFB);
        send_item(CMD_TABLE_HDR, 64'h0000_0001_0000_0000);
        repeat (5) send_item(CMD_TABLE_END, 64'd0);        // last one at depth zero
        send_item(CMD_UNUSED_LO + 4'($urandom_range(5)), {$urandom, $urandom});
        wait_idle();
    endtask

    task automatic test_nesting();
        // depth refusal wins over a full buffer
        write_reg(ADDR_MAX_DEPTH, 32'd1);
        write_reg(ADDR_BUFFER_LIMIT, 32'd2);
        send_item(CMD_BEGIN, 64'd0);
        send_item(CMD_TABLE_HDR, 64'd0);
        send_item(CMD_TABLE_HDR, 64'd0);
        send_item(CMD_NIL, 64'd0);                          // dropped, error pending
        wait_idle();
        write_reg(ADDR_MAX_DEPTH, 32'd15);
        write_reg(ADDR_BUFFER_LIMIT, 32'(BUF_BYTES));
        send_item(CMD_BEGIN, 64'd0);
        repeat (16) send_item(CMD_TABLE_HDR, 64'($urandom_range(40)));
        send_item(CMD_BEGIN, 64'd0);
        wait_idle();
    endtask

    task automatic test_buffer_limit();
        write_reg(ADDR_BUFFER_LIMIT, 32'd1);
        send_item(CMD_BEGIN, 64'd0);
        send_item(CMD_NIL, 64'd0);
        wait_idle();
        write_reg(ADDR_BUFFER_LIMIT, 32'd12);
        send_item(CMD_BEGIN, 64'd0);
        send_item(CMD_DOUBLE, {$urandom, $urandom});
        send_item(CMD_INTEGER, 64'd255);
        send_item(CMD_NIL, 64'd0);                          // reaches the limit
        send_item(CMD_NIL, 64'd0);
        send_item(CMD_BEGIN, 64'd0);
        send_item(CMD_NIL, 64'd0);
        wait_idle();
        write_reg(ADDR_BUFFER_LIMIT, 32'(BUF_BYTES));
        write_reg(ADDR_MAX_DEPTH, 32'(MAX_DEPTH_RST));
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(CMD_BEGIN, 64'd0);
        hold_left <= HOLD_CYCLES;
        repeat (30) send_item(($urandom_range(1) != 0) ? CMD_DOUBLE : CMD_INTEGER, rand_value());
        wait_idle();
    endtask

    task automatic test_random();
        int phase;
        int stop_at;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_reg(ADDR_BUFFER_LIMIT, 32'(BUF_BYTES));
                    write_reg(ADDR_MAX_DEPTH, 32'(MAX_DEPTH_RST));
                end
                1:
                begin
                    send_idle_pct  = 61;
                    recv_stall_pct = 0;
                    write_reg(ADDR_BUFFER_LIMIT, 32'($urandom_range(300, 24)));
                    write_reg(ADDR_MAX_DEPTH, 32'($urandom_range(15, 1)));
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 61;
                    write_reg(ADDR_BUFFER_LIMIT, 32'($urandom_range(2000, 300)));
                    write_reg(ADDR_MAX_DEPTH, 32'd15);
                end
                default:
                begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 7;
                    write_reg(ADDR_BUFFER_LIMIT, 32'($urandom_range(64, 8)));
                    write_reg(ADDR_MAX_DEPTH, 32'($urandom_range(4, 1)));
                end
            endcase
            send_item(CMD_BEGIN, 64'd0);
            stop_at = handled_items + ITEM_TARGET / 4;
            while (handled_items < stop_at)
                send_random_item();
            wait_idle();
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_scalar_forms();
        test_strings_tables();
        test_nesting();
        test_buffer_limit();
        test_backpressure();
        test_random();
        wait_idle();
        $display("tb_top: %0d items acted on, %0d output beats checked, %0d refused",
                 handled_items, beats_checked, refused_items);
        $display("tb_top: integer/string/table forms, depth and buffer limits, long stall");
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
